### src/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types and constants of the polynomial trajectory evaluator.
// ----------------------------------------------------------------------------
package pte_pkg;

  // store geometry
  localparam int SEGMENTS   = 16;
  localparam int COEFFS     = 8;
  localparam int AXES       = 3;
  localparam int CHAINS     = 3;

  // field widths
  localparam int SEG_IN_W   = 4;
  localparam int AXIS_W     = 2;
  localparam int CIDX_IN_W  = 3;
  localparam int COEF_W     = 48;
  localparam int TIME_W     = 32;
  localparam int RES_W      = 32;
  localparam int ACC_W      = 64;
  localparam int ORDER_W    = 3;

  // derived widths
  localparam int SEG_AW     = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int SEG_CMP_W  = 10;
  localparam int IDX_W      = $clog2(COEFFS);
  localparam int CNT_W      = $clog2(COEFFS + 1);
  localparam int ORD2_W     = ORDER_W + 1;
  localparam int FAC_W      = 2 * IDX_W;
  localparam int COEF_AW    = SEG_AW + AXIS_W + IDX_W;
  localparam int COEF_DEPTH = SEGMENTS * (2 ** AXIS_W) * (2 ** IDX_W);
  localparam int ACC_AW     = AXIS_W + 2;
  localparam int ACC_DEPTH  = 2 ** ACC_AW;

  localparam logic [ORDER_W-1:0] ORDER_RST = 3'd4;

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // one horner chain per derivative
  typedef enum logic [1:0] {
    CH_POS = 2'd0,
    CH_VEL = 2'd1,
    CH_ACC = 2'd2
  } chain_t;

  // control that travels with one multiply-accumulate step
  typedef struct packed {
    logic              active;
    logic              first;
    logic              last;
    logic [AXIS_W-1:0] ax;
    chain_t            ch;
    logic [IDX_W-1:0]  k;
  } mac_ctl_t;

endpackage

### src/poly_trajectory_evaluator_top.sv
// ----------------------------------------------------------------------------
// poly_trajectory_evaluator_top
// Piecewise polynomial trajectory evaluator with on-chip coefficient store.
//
// Input channel (in_valid/in_ready): a load request (kind 0) writes one
// coefficient into the coefficient RAM in the cycle it is accepted and
// returns nothing. An evaluate request (kind 1) returns one result on the
// out_ channel: position, velocity and acceleration for x, y and z.
// Config: cfg_we writes derivative_order; write only while the block is idle.
// Evaluation reads the coefficients of a segment highest power first, one
// word a cycle, and runs nine horner chains (3 derivatives x 3 axes)
// interleaved through one five-stage multiply-accumulate pipeline, one step
// a cycle. Running sums sit in a small accumulator RAM; a chain comes back
// only after its previous write-back. An evaluate request works through
// n = min(2*derivative_order, 8) coefficients per axis. A stalled receiver
// holds the result in the output register; loads and the next evaluation
// proceed until that result would be overwritten. Reset clears the control
// and sets derivative_order to 4; the coefficient RAM is not cleared.
// ----------------------------------------------------------------------------
module poly_trajectory_evaluator_top
  import pte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [SEG_IN_W-1:0]  in_segment,
  input  logic [AXIS_W-1:0]    in_axis,
  input  logic [CIDX_IN_W-1:0] in_coeff_index,
  input  logic [COEF_W-1:0]    in_coeff_value,
  input  logic [TIME_W-1:0]    in_local_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [RES_W-1:0]     out_pos_x,
  output logic [RES_W-1:0]     out_pos_y,
  output logic [RES_W-1:0]     out_pos_z,
  output logic [RES_W-1:0]     out_vel_x,
  output logic [RES_W-1:0]     out_vel_y,
  output logic [RES_W-1:0]     out_vel_z,
  output logic [RES_W-1:0]     out_acc_x,
  output logic [RES_W-1:0]     out_acc_y,
  output logic [RES_W-1:0]     out_acc_z,
  input  logic                 cfg_we,
  input  logic [ORDER_W-1:0]   cfg_wdata
);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;
  localparam int   DRAIN_LAT = 6;
  localparam int   DR_W      = $clog2(DRAIN_LAT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_HOLD
  } state_t;

  state_t             state_r;
  logic [ORDER_W-1:0] order_r;
  logic [SEG_AW-1:0]  seg_r;
  logic [TIME_W-1:0]  time_r;
  logic [CNT_W-1:0]   n_r;
  logic [IDX_W-1:0]   k_r;
  logic [AXIS_W-1:0]  ax_r;
  chain_t             ch_r;
  logic [DR_W-1:0]    drain_r;
  logic               out_valid_r;

  logic [RES_W-1:0] stage_r [CHAINS][AXES];
  logic [RES_W-1:0] out_r   [CHAINS][AXES];

  // request decode
  logic              in_acc, load_acc, eval_acc;
  logic              seg_ok, load_ok, eval_runs;
  logic [ORD2_W-1:0] ord2;
  logic [CNT_W-1:0]  n_nxt;

  always_comb begin
    in_acc    = in_valid && in_ready;
    load_acc  = in_acc && (in_kind == KIND_LOAD);
    eval_acc  = in_acc && (in_kind == KIND_EVAL);
    seg_ok    = SEG_CMP_W'(in_segment) < SEG_CMP_W'(SEGMENTS);
    load_ok   = seg_ok && (in_axis != 2'd3)
             && (ORD2_W'(in_coeff_index) < ORD2_W'(COEFFS));
    ord2      = {order_r, 1'b0};
    n_nxt     = (ord2 > ORD2_W'(COEFFS)) ? CNT_W'(COEFFS) : CNT_W'(ord2);
    eval_runs = seg_ok && (n_nxt != '0);
  end

  assign in_ready = (state_r == S_IDLE);

  // issue control for the step of the current chain
  mac_ctl_t iss;

  always_comb begin
    iss       = '0;
    iss.ax    = ax_r;
    iss.ch    = ch_r;
    iss.k     = k_r;
    iss.first = (CNT_W'(k_r) == n_r - CNT_W'(1));
    case (ch_r)
      CH_POS: begin
        iss.active = (state_r == S_RUN);
        iss.last   = (k_r == '0);
      end
      CH_VEL: begin
        iss.active = (state_r == S_RUN) && (k_r != '0);
        iss.last   = (CNT_W'(k_r) == CNT_W'(1));
      end
      CH_ACC: begin
        iss.active = (state_r == S_RUN) && (CNT_W'(k_r) >= CNT_W'(2));
        iss.last   = (CNT_W'(k_r) == CNT_W'(2));
      end
      default: begin
        iss.active = 1'b0;
        iss.last   = 1'b0;
      end
    endcase
  end

  // coefficient store
  logic [COEF_W-1:0] coef_rd;

  pte_ram #(
    .WIDTH (COEF_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (load_acc && load_ok),
    .waddr ({SEG_AW'(in_segment), in_axis, IDX_W'(in_coeff_index)}),
    .wdata (in_coeff_value),
    .raddr ({seg_r, ax_r, k_r}),
    .rdata (coef_rd)
  );

  // running sums, one entry per chain
  mac_ctl_t         wb, res;
  logic [ACC_W-1:0] wb_acc, acc_rd;
  logic [RES_W-1:0] res_val;

  pte_ram #(
    .WIDTH (ACC_W),
    .DEPTH (ACC_DEPTH)
  ) u_acc_ram (
    .clk   (clk),
    .we    (wb.active),
    .waddr ({wb.ax, wb.ch}),
    .wdata (wb_acc),
    .raddr ({ax_r, ch_r}),
    .rdata (acc_rd)
  );

  pte_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss_i     (iss),
    .time_i    (time_r),
    .coef_i    (coef_rd),
    .acc_i     (acc_rd),
    .wb_o      (wb),
    .wb_acc_o  (wb_acc),
    .res_o     (res),
    .res_val_o (res_val)
  );

  // finished sums collect here; chains with no terms stay zero
  always_ff @(posedge clk) begin
    if (eval_acc) begin
      for (int c = 0; c < CHAINS; c++) begin
        for (int a = 0; a < AXES; a++) begin
          stage_r[c][a] <= '0;
        end
      end
    end else if (res.active && res.last) begin
      stage_r[res.ch][res.ax] <= res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      order_r     <= ORDER_RST;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      ax_r        <= AXIS_X;
      ch_r        <= CH_POS;
      drain_r     <= '0;
    end else begin
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (eval_acc) begin
            seg_r   <= SEG_AW'(in_segment);
            time_r  <= in_local_time;
            n_r     <= n_nxt;
            k_r     <= IDX_W'(n_nxt - CNT_W'(1));
            ax_r    <= AXIS_X;
            ch_r    <= CH_POS;
            state_r <= eval_runs ? S_RUN : S_HOLD;
          end
        end
        S_RUN: begin
          // chain innermost, then axis, then power of t downward
          case (ch_r)
            CH_POS: ch_r <= CH_VEL;
            CH_VEL: ch_r <= CH_ACC;
            default: begin
              ch_r <= CH_POS;
              if (ax_r == AXIS_Z) begin
                ax_r <= AXIS_X;
                if (k_r == '0) begin
                  drain_r <= DR_W'(DRAIN_LAT - 1);
                  state_r <= S_DRAIN;
                end else begin
                  k_r <= k_r - IDX_W'(1);
                end
              end else begin
                ax_r <= ax_r + AXIS_W'(1);
              end
            end
          endcase
        end
        S_DRAIN: begin
          // wait for the last steps to leave the pipeline
          if (drain_r == '0) begin
            state_r <= S_HOLD;
          end else begin
            drain_r <= drain_r - DR_W'(1);
          end
        end
        S_HOLD: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_r       <= stage_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = out_r[CH_POS][AXIS_X];
  assign out_pos_y = out_r[CH_POS][AXIS_Y];
  assign out_pos_z = out_r[CH_POS][AXIS_Z];
  assign out_vel_x = out_r[CH_VEL][AXIS_X];
  assign out_vel_y = out_r[CH_VEL][AXIS_Y];
  assign out_vel_z = out_r[CH_VEL][AXIS_Z];
  assign out_acc_x = out_r[CH_ACC][AXIS_X];
  assign out_acc_y = out_r[CH_ACC][AXIS_Y];
  assign out_acc_z = out_r[CH_ACC][AXIS_Z];

endmodule

### src/pte_ram.sv
// ----------------------------------------------------------------------------
// pte_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/pte_mac.sv
// ----------------------------------------------------------------------------
// pte_mac
// Pipelined horner step: acc' = sat(rnd24(acc * t) + factor * c).
// ----------------------------------------------------------------------------
module pte_mac
  import pte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mac_ctl_t          iss_i,
  input  logic [TIME_W-1:0] time_i,
  input  logic [COEF_W-1:0] coef_i,
  input  logic [ACC_W-1:0]  acc_i,
  output mac_ctl_t          wb_o,
  output logic [ACC_W-1:0]  wb_acc_o,
  output mac_ctl_t          res_o,
  output logic [RES_W-1:0]  res_val_o
);

  localparam int PROD_W = 2 * TIME_W;
  localparam int SUM_W  = ACC_W + TIME_W;
  localparam int Q_W    = SUM_W - 24;
  localparam int ADD_W  = ACC_W + 2;
  localparam int RND_W  = ACC_W + 1;
  localparam int SH_W   = RND_W - 16;

  mac_ctl_t s1_r, s2_r, s3_r, s4_r, s5_r;

  logic                    s2_neg_r, s3_neg_r, s4_neg_r;
  logic [ACC_W-1:0]        s2_mag_r;
  logic signed [ACC_W-1:0] s2_d_r, s3_d_r, s4_d_r;
  logic [PROD_W-1:0]       s3_p0_r, s3_p1_r;
  logic [ACC_W-1:0]        s4_qc_r;
  logic [ACC_W-1:0]        s5_acc_r;

  // stage 1: magnitude of the running sum and the derivative coefficient
  logic [ACC_W-1:0]        acc_in;
  logic                    neg_nxt;
  logic [ACC_W-1:0]        mag_nxt;
  logic [FAC_W-1:0]        kf;
  logic [FAC_W-1:0]        fac;
  logic signed [ACC_W-1:0] d_nxt;

  always_comb begin
    acc_in  = s1_r.first ? '0 : acc_i;
    neg_nxt = acc_in[ACC_W-1];
    mag_nxt = neg_nxt ? (~acc_in + ACC_W'(1)) : acc_in;
    kf      = FAC_W'(s1_r.k);
    case (s1_r.ch)
      CH_POS:  fac = FAC_W'(1);
      CH_VEL:  fac = kf;
      CH_ACC:  fac = kf * (kf - FAC_W'(1));
      default: fac = '0;
    endcase
    d_nxt = $signed({{(ACC_W-COEF_W){coef_i[COEF_W-1]}}, coef_i})
          * $signed({{(ACC_W-FAC_W){1'b0}}, fac});
  end

  // stage 2: two 32x32 partial products
  logic [PROD_W-1:0] p0_nxt, p1_nxt;

  always_comb begin
    p0_nxt = PROD_W'(s2_mag_r[TIME_W-1:0]) * PROD_W'(time_i);
    p1_nxt = PROD_W'(s2_mag_r[ACC_W-1:TIME_W]) * PROD_W'(time_i);
  end

  // stage 3: sum partials, round at bit 24, clip to the signed range
  logic [SUM_W-1:0] sum96;
  logic [Q_W-1:0]   q;
  logic             q_ovf;
  logic [ACC_W-1:0] qc_nxt;

  always_comb begin
    sum96  = SUM_W'(s3_p0_r) + {s3_p1_r, {TIME_W{1'b0}}} + SUM_W'(24'h800000);
    q      = sum96[SUM_W-1:24];
    q_ovf  = (|q[Q_W-1:ACC_W]) | q[ACC_W-1];
    if (q_ovf) begin
      qc_nxt = s3_neg_r ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      qc_nxt = q[ACC_W-1:0];
    end
  end

  // stage 4: signed add of the scaled term, saturate to 64 bits
  logic signed [ADD_W-1:0] d_ext, q_ext, s66;
  logic                    s66_ovf;

  always_comb begin
    d_ext   = {{2{s4_d_r[ACC_W-1]}}, s4_d_r};
    q_ext   = {2'b00, s4_qc_r};
    s66     = s4_neg_r ? (d_ext - q_ext) : (d_ext + q_ext);
    s66_ovf = !((&s66[ADD_W-1:ACC_W-1]) || !(|s66[ADD_W-1:ACC_W-1]));
    if (s66_ovf) begin
      wb_acc_o = s66[ADD_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      wb_acc_o = s66[ACC_W-1:0];
    end
  end

  assign wb_o = s4_r;

  // stage 5: Q32.32 to Q16.16, nearest with ties away from zero
  logic signed [RND_W-1:0] rnd;
  logic [SH_W-1:0]         sh;
  logic                    sh_ovf;

  always_comb begin
    rnd    = $signed({s5_acc_r[ACC_W-1], s5_acc_r})
           + (s5_acc_r[ACC_W-1] ? RND_W'(16'h7fff) : RND_W'(16'h8000));
    sh     = rnd[RND_W-1:16];
    sh_ovf = !((&sh[SH_W-1:RES_W-1]) || !(|sh[SH_W-1:RES_W-1]));
    if (sh_ovf) begin
      res_val_o = sh[SH_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      res_val_o = sh[RES_W-1:0];
    end
  end

  assign res_o = s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
      s4_r <= '0;
      s5_r <= '0;
    end else begin
      s1_r <= iss_i;
      s2_r <= s1_r;
      s3_r <= s2_r;
      s4_r <= s3_r;
      s5_r <= s4_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_neg_r <= neg_nxt;
    s2_mag_r <= mag_nxt;
    s2_d_r   <= d_nxt;
    s3_neg_r <= s2_neg_r;
    s3_d_r   <= s2_d_r;
    s3_p0_r  <= p0_nxt;
    s3_p1_r  <= p1_nxt;
    s4_neg_r <= s3_neg_r;
    s4_d_r   <= s3_d_r;
    s4_qc_r  <= qc_nxt;
    s5_acc_r <= wb_acc_o;
  end

endmodule
